// ===== design/tipp_pkg.sv =====
// ----------------------------------------------------------------------------
// Tape image pulse player package
// Shared constants, command codes and controller/datapath link types.
// ----------------------------------------------------------------------------
package tipp_pkg;

   localparam int TAPE_DEPTH = 65536;
   localparam int ADDR_W     = $clog2(TAPE_DEPTH);
   localparam int POS_W      = 17;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_MOTOR = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [1:0] CSR_TAPE_LENGTH = 2'd0;
   localparam logic [1:0] CSR_ONE_HALF    = 2'd1;
   localparam logic [1:0] CSR_ZERO_HALF   = 2'd2;

   localparam logic [7:0]  SYNC_BYTE    = 8'h16;
   localparam logic [7:0]  SYNC_END     = 8'h24;
   localparam logic [6:0]  LEAD_REPEATS = 7'd80;
   localparam logic [10:0] BODY_PAUSE   = 11'd1281;
   localparam logic [3:0]  LAST_SLOT    = 4'd13;
   localparam logic [3:0]  PARITY_SLOT  = 4'd10;
   localparam logic [1:0]  MIN_SYNC     = 2'd3;
   localparam logic [4:0]  FIXED_SKIP   = 5'd10;

   typedef struct packed {
      logic capture;
      logic mem_write;
      logic sel_scan;
      logic motor_off;
      logic motor_on;
      logic tick;
      logic scan_sync;
      logic scan_fixed;
      logic scan_name;
      logic scan_found;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic running;
      logic at_end;
      logic is_sync;
      logic is_end;
      logic is_zero;
      logic sync_ok;
      logic fixed_over;
   } status_type;

endpackage

// ===== design/tipp_datapath.sv =====
// ----------------------------------------------------------------------------
// Tape image pulse player datapath
// Tape memory, playback state, header scan pointer and result registers.
// ----------------------------------------------------------------------------
module tipp_datapath (
   input  logic                clock,
   input  logic                reset,
   input  tipp_pkg::cmd_type   cmd,
   output tipp_pkg::status_type status,
   input  logic                csr_write_enable,
   input  logic [1:0]          csr_index,
   input  logic [16:0]         csr_write_data,
   input  logic [15:0]         req_tape_address,
   input  logic [7:0]          req_tape_byte,
   input  logic [7:0]          req_elapsed_cycles,
   output logic                rsp_pulse_level,
   output logic                rsp_pulse_toggled,
   output logic [7:0]          rsp_cycles_used,
   output logic                rsp_header_found
);
   import tipp_pkg::*;

   logic [7:0]       mem [TAPE_DEPTH];
   logic [7:0]       mem_q_ff;
   logic [ADDR_W-1:0] rd_addr;

   logic [16:0] len_ff;
   logic [11:0] one_ff, zero_ff;
   logic [7:0]  elapsed_ff;

   logic [POS_W-1:0] pos_ff, pos_in, body_ff, ptr_ff;
   logic [3:0]  slot_ff, slot_in;
   logic        bit_ff, bit_in, par_ff, par_in, level_ff, level_in, run_ff;
   logic [11:0] half_ff, half_in;
   logic [10:0] pause_ff, pause_in;
   logic [6:0]  rep_ff, rep_in;
   logic [1:0]  nsync_ff;
   logic        toggle_now, active;
   logic [11:0] pdiff;
   logic [2:0]  sidx;
   logic [17:0] fixed_end;

   assign rd_addr = cmd.sel_scan ? ptr_ff[ADDR_W-1:0] : pos_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         mem[req_tape_address[ADDR_W-1:0]] <= req_tape_byte;
      end
      mem_q_ff <= mem[rd_addr];
   end

   assign active    = (elapsed_ff != 8'd0) && run_ff;
   assign pdiff     = {1'b0, pause_ff} - {4'd0, elapsed_ff};
   assign sidx      = slot_ff[2:0] - 3'd2;
   assign fixed_end = {1'b0, ptr_ff} + {13'd0, FIXED_SKIP};

   always_comb begin
      pos_in     = pos_ff;
      slot_in    = slot_ff;
      bit_in     = bit_ff;
      par_in     = par_ff;
      level_in   = level_ff;
      half_in    = half_ff;
      pause_in   = pause_ff;
      rep_in     = rep_ff;
      toggle_now = 1'b0;
      if (cmd.motor_off && slot_ff != 4'd0) begin
         pos_in  = pos_ff + 1'b1;
         slot_in = 4'd0;
      end
      if (cmd.scan_found) begin
         rep_in = LEAD_REPEATS;
      end
      if (cmd.tick && active) begin
         if (half_ff > {4'd0, elapsed_ff}) begin
            half_in = half_ff - {4'd0, elapsed_ff};
            if (pause_ff != 11'd0) begin
               pause_in = pdiff[11] ? 11'd1 : pdiff[10:0];
            end
         end else begin
            level_in   = ~level_ff;
            toggle_now = 1'b1;
            if (pause_ff != 11'd0) begin
               pause_in = (pdiff[11] || pdiff == 12'd0) ? {10'd0, ~level_ff} : pdiff[10:0];
               half_in  = one_ff;
            end else begin
               if (~level_ff) begin
                  case (slot_ff)
                     4'd0: begin
                        bit_in  = 1'b1;
                        slot_in = 4'd1;
                     end
                     4'd1: begin
                        bit_in  = 1'b0;
                        par_in  = 1'b1;
                        slot_in = 4'd2;
                     end
                     4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9: begin
                        bit_in  = mem_q_ff[sidx];
                        par_in  = par_ff ^ mem_q_ff[sidx];
                        slot_in = slot_ff + 1'b1;
                     end
                     PARITY_SLOT: begin
                        bit_in  = par_ff;
                        slot_in = slot_ff + 1'b1;
                     end
                     default: begin
                        bit_in  = 1'b1;
                        slot_in = slot_ff + 1'b1;
                        if (slot_ff == LAST_SLOT) begin
                           slot_in = 4'd0;
                           if (rep_ff != 7'd0) begin
                              rep_in = rep_ff - 1'b1;
                           end else begin
                              pos_in = pos_ff + 1'b1;
                           end
                           if (((rep_ff != 7'd0) ? pos_ff : pos_ff + 1'b1) == body_ff) begin
                              pause_in = BODY_PAUSE;
                           end
                        end
                     end
                  endcase
               end
               half_in = bit_in ? one_ff : zero_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= 17'd0;
         one_ff   <= 12'd208;
         zero_ff  <= 12'd416;
         pos_ff   <= '0;
         body_ff  <= '0;
         slot_ff  <= 4'd0;
         bit_ff   <= 1'b0;
         par_ff   <= 1'b1;
         level_ff <= 1'b0;
         half_ff  <= 12'd2;
         pause_ff <= 11'd0;
         rep_ff   <= 7'd0;
         run_ff   <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TAPE_LENGTH: len_ff  <= (csr_write_data > 17'(TAPE_DEPTH)) ?
                                           17'(TAPE_DEPTH) : csr_write_data;
               CSR_ONE_HALF:    one_ff  <= csr_write_data[11:0];
               CSR_ZERO_HALF:   zero_ff <= csr_write_data[11:0];
               default: ;
            endcase
         end
         pos_ff   <= pos_in;
         slot_ff  <= slot_in;
         bit_ff   <= bit_in;
         par_ff   <= par_in;
         level_ff <= level_in;
         half_ff  <= half_in;
         pause_ff <= pause_in;
         rep_ff   <= rep_in;
         if (cmd.motor_off) begin
            run_ff <= 1'b0;
         end else if (cmd.motor_on) begin
            run_ff <= 1'b1;
         end
         if (cmd.scan_found) begin
            body_ff <= ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         elapsed_ff <= req_elapsed_cycles;
      end
      if (cmd.motor_on) begin
         ptr_ff   <= pos_ff;
         nsync_ff <= 2'd0;
      end else if (cmd.scan_sync || cmd.scan_name) begin
         ptr_ff   <= ptr_ff + 1'b1;
         nsync_ff <= (nsync_ff == MIN_SYNC) ? nsync_ff : nsync_ff + 1'b1;
      end else if (cmd.scan_fixed) begin
         ptr_ff <= fixed_end[POS_W-1:0];
      end
      if (cmd.rsp_load) begin
         rsp_pulse_toggled <= cmd.tick & toggle_now;
         rsp_cycles_used   <= (cmd.tick && active) ? elapsed_ff : 8'd0;
         rsp_header_found  <= cmd.scan_found;
      end
   end

   assign rsp_pulse_level = level_ff;

   assign status.running    = run_ff;
   assign status.at_end     = ptr_ff >= len_ff;
   assign status.is_sync    = mem_q_ff == SYNC_BYTE;
   assign status.is_end     = mem_q_ff == SYNC_END;
   assign status.is_zero    = mem_q_ff == 8'd0;
   assign status.sync_ok    = nsync_ff == MIN_SYNC;
   assign status.fixed_over = fixed_end >= {1'b0, len_ff};

endmodule

// ===== design/tipp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Tape image pulse player controller
// Item handshake, header scan sequencing and result slot control.
// ----------------------------------------------------------------------------
module tipp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_command,
   input  logic                 req_motor_on,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  tipp_pkg::status_type status,
   output tipp_pkg::cmd_type    cmd
);
   import tipp_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_TICK   = 3'd1;
   localparam logic [2:0] ST_SC_RD  = 3'd2;
   localparam logic [2:0] ST_SC_CHK = 3'd3;
   localparam logic [2:0] ST_NM_RD  = 3'd4;
   localparam logic [2:0] ST_NM_CHK = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, accept;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               case (req_command)
                  CMD_WRITE: begin
                     cmd.mem_write = 1'b1;
                     cmd.rsp_load  = 1'b1;
                  end
                  CMD_MOTOR: begin
                     if (req_motor_on == status.running) begin
                        cmd.rsp_load = 1'b1;
                     end else if (req_motor_on) begin
                        cmd.motor_on = 1'b1;
                        state_in     = ST_SC_RD;
                     end else begin
                        cmd.motor_off = 1'b1;
                        cmd.rsp_load  = 1'b1;
                     end
                  end
                  CMD_TICK: state_in = ST_TICK;
                  default:  cmd.rsp_load = 1'b1;
               endcase
            end
         end
         ST_TICK: begin
            cmd.tick     = 1'b1;
            cmd.rsp_load = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SC_RD, ST_NM_RD: begin
            cmd.sel_scan = 1'b1;
            if (status.at_end) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               state_in = (state_ff == ST_SC_RD) ? ST_SC_CHK : ST_NM_CHK;
            end
         end
         ST_SC_CHK: begin
            if (status.is_sync) begin
               cmd.scan_sync = 1'b1;
               state_in      = ST_SC_RD;
            end else if (status.sync_ok && status.is_end && !status.fixed_over) begin
               cmd.scan_fixed = 1'b1;
               state_in       = ST_NM_RD;
            end else begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_NM_CHK: begin
            if (status.is_zero) begin
               cmd.scan_found = 1'b1;
               cmd.rsp_load   = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.scan_name = 1'b1;
               state_in      = ST_NM_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== design/tape_image_pulse_player_core.sv =====
// ----------------------------------------------------------------------------
// Tape image pulse player core
// Plays a stored tape image as a train of level changes, one per half bit.
// ----------------------------------------------------------------------------
// A write, a motor-off or an unchanged motor request is answered from the
// idle state; an advance first reads the current tape byte from the
// registered memory read port and then updates the pulse state. A
// motor-on runs a header scan over that same port: a start step, then a
// read and a check for each tape byte examined, sync and name bytes alike.
// Results wait in an output register, and the next item is taken in the
// cycle that result is collected.
module tape_image_pulse_player_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [15:0] req_tape_address,
   input  logic [7:0]  req_tape_byte,
   input  logic        req_motor_on,
   input  logic [7:0]  req_elapsed_cycles,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_pulse_level,
   output logic        rsp_pulse_toggled,
   output logic [7:0]  rsp_cycles_used,
   output logic        rsp_header_found,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_write_data
);
   import tipp_pkg::*;

   cmd_type    cmd;
   status_type status;

   tipp_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_command  (req_command),
      .req_motor_on (req_motor_on),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .status       (status),
      .cmd          (cmd)
   );

   tipp_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_tape_address   (req_tape_address),
      .req_tape_byte      (req_tape_byte),
      .req_elapsed_cycles (req_elapsed_cycles),
      .rsp_pulse_level    (rsp_pulse_level),
      .rsp_pulse_toggled  (rsp_pulse_toggled),
      .rsp_cycles_used    (rsp_cycles_used),
      .rsp_header_found   (rsp_header_found)
   );

`ifndef SYNTH
   a_ready_slot_free: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("item taken while result slot occupied");

   a_toggle_spends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pulse_toggled) |-> (rsp_cycles_used != 8'd0))
      else $error("level toggled without cycles spent");

   a_found_no_cycles: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_header_found) |-> (rsp_cycles_used == 8'd0 && !rsp_pulse_toggled))
      else $error("header result carries tick fields");

   a_load_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_command == CMD_TICK) |=> !rsp_valid)
      else $error("advance result shown too early");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tape image pulse player testbench
// Drives write, motor and tick items through the request channel with random
// gaps and response stalls. Results are checked against a local model of the
// tape memory, header scan and frame serializer, the opening ones against fixed
// values. The run covers several register settings, including the extremes.
// ----------------------------------------------------------------------------
module tb_top;
   import tipp_pkg::*;

   localparam logic [1:0] CMD_NONE = 2'd3;

   typedef struct packed {
      logic       level;
      logic       toggled;
      logic [7:0] used;
      logic       found;
   } pulse_result_type;

   typedef struct packed {
      logic [1:0]       command;
      logic [15:0]      address;
      logic [7:0]       data;
      logic             motor;
      logic [7:0]       elapsed;
      logic             typed;
      pulse_result_type result;
   } tape_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_command = CMD_WRITE;
   logic [15:0] req_tape_address = '0;
   logic [7:0]  req_tape_byte = '0;
   logic        req_motor_on = 1'b0;
   logic [7:0]  req_elapsed_cycles = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_pulse_level;
   logic        rsp_pulse_toggled;
   logic [7:0]  rsp_cycles_used;
   logic        rsp_header_found;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = CSR_TAPE_LENGTH;
   logic [16:0] csr_write_data = '0;

   tape_image_pulse_player_core i_dut (.*);

   always #5 clock = ~clock;

   // local copy of the player state
   logic [7:0]  tape_mem [TAPE_DEPTH];
   bit          tape_known [TAPE_DEPTH];
   logic [16:0] tape_len;
   logic [11:0] one_half, zero_half;
   logic [16:0] play_pos, body_pos;
   logic [3:0]  slot;
   logic        cur_bit, parity, lvl, motor;
   logic [11:0] half_left;
   int          pause_cnt;
   logic [6:0]  lead_left;

   pulse_result_type expected_pulses [$];
   int               errors = 0;
   int               item_count = 0;
   int               stall_left = 0;

   function automatic int span_limit();
      return (tape_len > TAPE_DEPTH) ? TAPE_DEPTH : int'(tape_len);
   endfunction

   // returns the first never-written address a header scan would read, or -1
   function automatic int scan_hole();
      int len, p, n;
      len = span_limit();
      p = int'(play_pos);
      n = 0;
      while (p < len) begin
         if (!tape_known[p]) return p;
         if (tape_mem[p] != SYNC_BYTE) break;
         p++;
         n++;
      end
      if (p >= len || n < 3) return -1;
      if (!tape_known[p]) return p;
      if (tape_mem[p] != SYNC_END) return -1;
      p++;
      if (p + 9 >= len) return -1;
      p += 9;
      while (p < len) begin
         if (!tape_known[p]) return p;
         if (tape_mem[p] == 8'h00) return -1;
         p++;
      end
      return -1;
   endfunction

   function automatic bit scan_header();
      int len, p, n;
      len = span_limit();
      p = int'(play_pos);
      n = 0;
      while (p < len && tape_mem[p] == SYNC_BYTE) begin
         p++;
         n++;
      end
      if (p >= len || n < 3 || tape_mem[p] != SYNC_END) return 1'b0;
      p++;
      if (p + 9 >= len) return 1'b0;
      p += 9;
      forever begin
         if (p >= len) return 1'b0;
         if (tape_mem[p] == 8'h00) break;
         p++;
      end
      body_pos = 17'(p + 1);
      lead_left = LEAD_REPEATS;
      return 1'b1;
   endfunction

   function automatic logic frame_bit();
      logic [7:0] b;
      logic       v;
      b = tape_mem[play_pos[15:0]];
      if (slot == 4'd0) begin
         v = 1'b1;
         slot = 4'd1;
      end else if (slot == 4'd1) begin
         v = 1'b0;
         parity = 1'b1;
         slot = 4'd2;
      end else if (slot <= 4'd9) begin
         v = b[slot - 4'd2];
         parity ^= v;
         slot++;
      end else if (slot == PARITY_SLOT) begin
         v = parity;
         slot = 4'd11;
      end else begin
         v = 1'b1;
         if (slot == LAST_SLOT) begin
            slot = 4'd0;
            if (lead_left > 0) lead_left--;
            else play_pos = play_pos + 17'd1;
            if (play_pos == body_pos) pause_cnt = int'(BODY_PAUSE);
         end else begin
            slot++;
         end
      end
      return v;
   endfunction

   function automatic pulse_result_type tape_step(tape_item_type it);
      pulse_result_type r;
      int               c;
      r = '0;
      if (it.command == CMD_WRITE) begin
         tape_mem[it.address] = it.data;
         tape_known[it.address] = 1'b1;
      end else if (it.command == CMD_MOTOR) begin
         if (it.motor != motor) begin
            motor = it.motor;
            if (!it.motor) begin
               if (slot != 4'd0) begin
                  play_pos = play_pos + 17'd1;
                  slot = 4'd0;
               end
            end else begin
               r.found = scan_header();
            end
         end
      end else if (it.command == CMD_TICK) begin
         c = int'(it.elapsed);
         if (c != 0 && motor) begin
            r.used = it.elapsed;
            if (half_left > c) begin
               half_left = half_left - 12'(c);
               if (pause_cnt > 0) begin
                  pause_cnt -= c;
                  if (pause_cnt < 0) pause_cnt = 1;
               end
            end else begin
               lvl = ~lvl;
               r.toggled = 1'b1;
               if (pause_cnt > 0) begin
                  pause_cnt -= c;
                  if (pause_cnt <= 0) pause_cnt = lvl ? 1 : 0;
                  half_left = one_half;
               end else begin
                  if (lvl) cur_bit = frame_bit();
                  half_left = cur_bit ? one_half : zero_half;
               end
            end
         end
      end
      r.level = lvl;
      return r;
   endfunction

   task automatic send_item(tape_item_type it);
      int gap;
      pulse_result_type r;
      r = tape_step(it);
      expected_pulses.push_back(it.typed ? it.result : r);
      item_count++;
      gap = ($urandom_range(0, 3) == 0) ? (($urandom_range(0, 15) == 0) ?
            $urandom_range(20, 60) : $urandom_range(1, 3)) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= it.command;
      req_tape_address <= it.address;
      req_tape_byte <= it.data;
      req_motor_on <= it.motor;
      req_elapsed_cycles <= it.elapsed;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_cmd(logic [1:0] cmd, logic [15:0] a, logic [7:0] d,
                           logic m, logic [7:0] e);
      tape_item_type it;
      it = '{command: cmd, address: a, data: d, motor: m, elapsed: e,
             typed: 1'b0, result: '0};
      send_item(it);
   endtask

   function automatic logic [7:0] filler();
      case ($urandom_range(0, 3))
         0: return 8'h00;
         1: return SYNC_BYTE;
         2: return SYNC_END;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic motor_start();
      int h;
      h = scan_hole();
      while (h >= 0) begin
         send_cmd(CMD_WRITE, 16'(h), filler(), 1'b0, 8'h00);
         h = scan_hole();
      end
      send_cmd(CMD_MOTOR, 16'($urandom), 8'($urandom), 1'b1, 8'($urandom));
   endtask

   task automatic tick(logic [7:0] e);
      if (!tape_known[play_pos[15:0]])
         send_cmd(CMD_WRITE, play_pos[15:0], 8'($urandom), 1'b0, 8'h00);
      send_cmd(CMD_TICK, 16'($urandom), 8'($urandom), 1'($urandom), e);
   endtask

   // lay a header at the current position; broken variants at random
   task automatic lay_header(bit intact);
      int k, nsync, nname;
      logic [15:0] a;
      a = play_pos[15:0];
      nsync = intact ? $urandom_range(3, 5) : $urandom_range(1, 3);
      for (k = 0; k < nsync; k++) begin
         send_cmd(CMD_WRITE, a, SYNC_BYTE, 1'b0, 8'h00);
         a++;
      end
      send_cmd(CMD_WRITE, a, (intact || $urandom_range(0, 1)) ? SYNC_END : 8'h42,
               1'b0, 8'h00);
      a++;
      for (k = 0; k < 9; k++) begin
         send_cmd(CMD_WRITE, a, 8'($urandom), 1'b0, 8'h00);
         a++;
      end
      nname = $urandom_range(0, 3);
      for (k = 0; k < nname; k++) begin
         send_cmd(CMD_WRITE, a, 8'($urandom_range(1, 255)), 1'b0, 8'h00);
         a++;
      end
      send_cmd(CMD_WRITE, a, 8'h00, 1'b0, 8'h00);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pulses.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [16:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_TAPE_LENGTH) tape_len = val;
      else if (idx == CSR_ONE_HALF) one_half = val[11:0];
      else if (idx == CSR_ZERO_HALF) zero_half = val[11:0];
   endtask

   task automatic play_phase(int target);
      int start, k, n;
      start = item_count;
      while (item_count - start < target) begin
         if (motor) send_cmd(CMD_MOTOR, 16'($urandom), 8'($urandom), 1'b0, 8'($urandom));
         if ($urandom_range(0, 4) != 0) lay_header($urandom_range(0, 3) != 0);
         motor_start();
         n = $urandom_range(20, 60);
         for (k = 0; k < n; k++) begin
            case ($urandom_range(0, 19))
               0: send_cmd(CMD_WRITE, 16'($urandom), 8'($urandom), 1'($urandom),
                           8'($urandom));
               1: send_cmd(CMD_NONE, 16'($urandom), 8'($urandom), 1'($urandom),
                           8'($urandom));
               2: send_cmd(CMD_MOTOR, 16'($urandom), 8'($urandom), 1'b0, 8'($urandom));
               3: motor_start();
               4: tick(8'h00);
               5: tick(8'($urandom_range(1, 15)));
               default: tick(8'($urandom));
            endcase
         end
      end
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 63) == 0) begin
         stall_left <= $urandom_range(20, 60);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      pulse_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pulses.size() == 0) begin
            $display("%0t: unexpected item level=%0d", $time, rsp_pulse_level);
            errors++;
         end else begin
            e = expected_pulses.pop_front();
            if (rsp_pulse_level !== e.level) begin
               $display("%0t: pulse_level exp %0d got %0d", $time, e.level,
                        rsp_pulse_level);
               errors++;
            end
            if (rsp_pulse_toggled !== e.toggled) begin
               $display("%0t: pulse_toggled exp %0d got %0d", $time, e.toggled,
                        rsp_pulse_toggled);
               errors++;
            end
            if (rsp_cycles_used !== e.used) begin
               $display("%0t: cycles_used exp %0d got %0d", $time, e.used,
                        rsp_cycles_used);
               errors++;
            end
            if (rsp_header_found !== e.found) begin
               $display("%0t: header_found exp %0d got %0d", $time, e.found,
                        rsp_header_found);
               errors++;
            end
         end
      end
   end

   tape_item_type opening [11] = '{
      '{CMD_TICK,  16'h0000, 8'h00, 1'b0, 8'hFF, 1'b1, '{1'b0, 1'b0, 8'd0,   1'b0}},
      '{CMD_NONE,  16'hFFFF, 8'hFF, 1'b1, 8'hFF, 1'b1, '{1'b0, 1'b0, 8'd0,   1'b0}},
      '{CMD_MOTOR, 16'h0000, 8'h00, 1'b0, 8'h00, 1'b1, '{1'b0, 1'b0, 8'd0,   1'b0}},
      '{CMD_WRITE, 16'h0000, 8'h00, 1'b0, 8'h00, 1'b1, '{1'b0, 1'b0, 8'd0,   1'b0}},
      '{CMD_WRITE, 16'hFFFF, 8'hFF, 1'b0, 8'h00, 1'b1, '{1'b0, 1'b0, 8'd0,   1'b0}},
      '{CMD_MOTOR, 16'h0000, 8'h00, 1'b1, 8'h00, 1'b1, '{1'b0, 1'b0, 8'd0,   1'b0}},
      '{CMD_TICK,  16'h0000, 8'h00, 1'b0, 8'h00, 1'b1, '{1'b0, 1'b0, 8'd0,   1'b0}},
      '{CMD_TICK,  16'h0000, 8'h00, 1'b0, 8'h01, 1'b1, '{1'b0, 1'b0, 8'd1,   1'b0}},
      '{CMD_TICK,  16'h0000, 8'h00, 1'b0, 8'hFF, 1'b1, '{1'b1, 1'b1, 8'd255, 1'b0}},
      '{CMD_MOTOR, 16'h0000, 8'h00, 1'b1, 8'h00, 1'b1, '{1'b1, 1'b0, 8'd0,   1'b0}},
      '{CMD_MOTOR, 16'h0000, 8'h00, 1'b0, 8'h00, 1'b1, '{1'b1, 1'b0, 8'd0,   1'b0}}
   };

   initial begin
      int k;
      tape_len = '0;
      one_half = 12'd208;
      zero_half = 12'd416;
      play_pos = '0;
      body_pos = '0;
      slot = '0;
      cur_bit = 1'b0;
      parity = 1'b1;
      lvl = 1'b0;
      half_left = 12'd2;
      pause_cnt = 0;
      lead_left = '0;
      motor = 1'b0;
      for (k = 0; k < TAPE_DEPTH; k++) begin
         tape_mem[k] = 8'h00;
         tape_known[k] = 1'b0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (k = 0; k < 11; k++) send_item(opening[k]);
      play_phase(40);
      settle();

      // lead-in at the fastest rate
      csr_write(CSR_TAPE_LENGTH, 17'd65536);
      csr_write(CSR_ONE_HALF, 17'd1);
      csr_write(CSR_ZERO_HALF, 17'd1);
      if (motor) send_cmd(CMD_MOTOR, 16'h0, 8'h0, 1'b0, 8'h0);
      lay_header(1'b1);
      motor_start();
      for (k = 0; k < 60; k++) tick(8'($urandom_range(1, 255)));
      settle();

      csr_write(CSR_TAPE_LENGTH, 17'd300);
      csr_write(CSR_ONE_HALF, 17'd4095);
      csr_write(CSR_ZERO_HALF, 17'd1);
      play_phase(70);
      settle();
      csr_write(CSR_TAPE_LENGTH, 17'd65535);
      csr_write(CSR_ONE_HALF, 17'd0);
      csr_write(CSR_ZERO_HALF, 17'd4095);
      play_phase(70);
      settle();
      csr_write(CSR_TAPE_LENGTH, 17'h1FFFF);
      csr_write(CSR_ONE_HALF, 17'd2);
      csr_write(CSR_ZERO_HALF, 17'd0);
      play_phase(80);
      settle();
      csr_write(CSR_TAPE_LENGTH, 17'd0);
      csr_write(CSR_ONE_HALF, 17'd208);
      csr_write(CSR_ZERO_HALF, 17'd416);
      play_phase(50);
      settle();
      csr_write(CSR_TAPE_LENGTH, 17'($urandom_range(20, 4000)));
      csr_write(CSR_ONE_HALF, 17'($urandom_range(1, 40)));
      csr_write(CSR_ZERO_HALF, 17'($urandom_range(1, 40)));
      play_phase(100);
      settle();
      repeat (20) @(posedge clock);

      if (errors == 0 && expected_pulses.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
design/tipp_pkg.sv
design/tipp_datapath.sv
design/tipp_ctrl.sv
design/tape_image_pulse_player_core.sv
dv/tb_top.sv
